FILE: rtl/dwdf_pkg.sv
// ----------------------------------------------------------------------------
// dwdf_pkg
// Shared types and constants for the DMA width divider finder.
// ----------------------------------------------------------------------------
package dwdf_pkg;

  localparam int unsigned LengthBitsDef = 32;
  localparam int unsigned FieldW        = 32;
  localparam int unsigned DividerW      = 16;
  localparam int unsigned StatusW       = 2;
  localparam logic [FieldW-1:0] DefaultUnit = 32'd16;

  typedef enum logic [StatusW-1:0] {
    StOk         = 2'd0,
    StZero       = 2'd1,
    StMisaligned = 2'd2
  } status_e;

  typedef struct packed {
    logic    load;
    logic    mod_start;
    logic    mod_sel_w;
    logic    sqrt_init;
    logic    sqrt_step;
    logic    w_from_root;
    logic    w_dec;
    logic    res_load;
    status_e res_status;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic mod_done;
    logic rem_zero;
    logic sqrt_last;
  } sts_t;

endpackage

FILE: rtl/dwdf_mod.sv
// ----------------------------------------------------------------------------
// dwdf_mod
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module dwdf_mod #(
  parameter int unsigned LEN_W = dwdf_pkg::LengthBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [LEN_W-1:0]            dividend_i,
  input  logic [dwdf_pkg::FieldW-1:0] divisor_i,
  output logic                        done_o,
  output logic                        rem_zero_o
);
  import dwdf_pkg::*;

  localparam int unsigned CntW = $clog2(LEN_W + 1);
  localparam int unsigned CmpW = FieldW + 1;

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [LEN_W-1:0]  dvd_q;
  logic [FieldW-1:0] dvs_q;

  logic [LEN_W:0]  shifted;
  logic [CmpW-1:0] shifted_ext;
  logic [CmpW-1:0] divisor_ext;
  logic [CmpW-1:0] diff;

  always_comb begin
    shifted     = {rem_q, dvd_q[LEN_W-1]};
    shifted_ext = CmpW'(shifted);
    divisor_ext = {1'b0, dvs_q};
    diff        = shifted_ext - divisor_ext;
    if (shifted_ext >= divisor_ext) begin
      rem_d = diff[LEN_W-1:0];
    end else begin
      rem_d = shifted[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(LEN_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[LEN_W-2:0], 1'b0};
    end
  end

  assign done_o     = done_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

FILE: rtl/dwdf_dp.sv
// ----------------------------------------------------------------------------
// dwdf_dp
// Datapath: operand capture, bitwise square root, divisor search, result.
// ----------------------------------------------------------------------------
module dwdf_dp #(
  parameter int unsigned LEN_W = dwdf_pkg::LengthBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dwdf_pkg::cmd_t                cmd_i,
  input  logic [dwdf_pkg::FieldW-1:0]   length_i,
  input  logic [dwdf_pkg::FieldW-1:0]   unit_size_i,
  output dwdf_pkg::sts_t                sts_o,
  output logic [dwdf_pkg::DividerW-1:0] divider_o,
  output logic [dwdf_pkg::StatusW-1:0]  status_o
);
  import dwdf_pkg::*;

  localparam int unsigned RootW  = (LEN_W + 1) / 2;
  localparam int unsigned TopBit = ((LEN_W - 1) / 2) * 2;

  logic [LEN_W-1:0]    len_q;
  logic [FieldW-1:0]   unit_q;
  logic [LEN_W-1:0]    srem_q;
  logic [LEN_W-1:0]    sacc_q;
  logic [LEN_W-1:0]    probe_q;
  logic [RootW-1:0]    w_q;
  logic [DividerW-1:0] div_q;
  logic [StatusW-1:0]  st_q;

  logic [LEN_W:0]    trial;
  logic              take;
  logic [FieldW-1:0] mod_divisor;
  logic              mod_done;
  logic              mod_rem_zero;

  always_comb begin
    trial = {1'b0, sacc_q} + {1'b0, probe_q};
    take  = ({1'b0, srem_q} >= trial);
    if (cmd_i.mod_sel_w) begin
      mod_divisor = FieldW'(w_q);
    end else begin
      mod_divisor = unit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      len_q <= length_i[LEN_W-1:0];
      if (unit_size_i == '0) begin
        unit_q <= DefaultUnit;
      end else begin
        unit_q <= unit_size_i;
      end
    end
    if (cmd_i.sqrt_init) begin
      srem_q  <= len_q;
      sacc_q  <= '0;
      probe_q <= LEN_W'(1) << TopBit;
    end else if (cmd_i.sqrt_step) begin
      if (take) begin
        srem_q <= srem_q - trial[LEN_W-1:0];
        sacc_q <= (sacc_q >> 1) + probe_q;
      end else begin
        sacc_q <= sacc_q >> 1;
      end
      probe_q <= probe_q >> 2;
    end
    if (cmd_i.w_from_root) begin
      w_q <= sacc_q[RootW-1:0];
    end else if (cmd_i.w_dec) begin
      w_q <= w_q - RootW'(1);
    end
    if (cmd_i.res_load) begin
      st_q <= cmd_i.res_status;
      if (cmd_i.res_status == StOk) begin
        div_q <= DividerW'(w_q);
      end else begin
        div_q <= '0;
      end
    end
  end

  dwdf_mod #(
    .LEN_W(LEN_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (len_q),
    .divisor_i  (mod_divisor),
    .done_o     (mod_done),
    .rem_zero_o (mod_rem_zero)
  );

  assign sts_o.len_zero  = (len_q == '0);
  assign sts_o.mod_done  = mod_done;
  assign sts_o.rem_zero  = mod_rem_zero;
  assign sts_o.sqrt_last = probe_q[0];
  assign divider_o       = div_q;
  assign status_o        = st_q;

endmodule

FILE: rtl/dwdf_ctrl.sv
// ----------------------------------------------------------------------------
// dwdf_ctrl
// Controller: sequences checks, root, divisor search and result handoff.
// ----------------------------------------------------------------------------
module dwdf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  input  dwdf_pkg::sts_t sts_i,
  output dwdf_pkg::cmd_t cmd_o
);
  import dwdf_pkg::*;

  typedef enum logic [2:0] {
    SIdle,
    SCheck,
    SModUnit,
    SSqrt,
    SRootLoad,
    STry,
    SModW,
    SFinish
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    m_tvalid_q, m_tvalid_d;
  logic    out_free;

  assign out_free   = !m_tvalid_q || m_tready_i;
  assign s_tready_o = (state_q == SIdle);
  assign m_tvalid_o = m_tvalid_q;

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    m_tvalid_d = m_tvalid_q && !m_tready_i;
    cmd_o      = '0;
    cmd_o.res_status = st_q;
    unique case (state_q)
      SIdle: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SCheck;
        end
      end
      SCheck: begin
        if (sts_i.len_zero) begin
          st_d    = StZero;
          state_d = SFinish;
        end else begin
          cmd_o.mod_start = 1'b1;
          state_d         = SModUnit;
        end
      end
      SModUnit: begin
        if (sts_i.mod_done) begin
          if (sts_i.rem_zero) begin
            cmd_o.sqrt_init = 1'b1;
            state_d         = SSqrt;
          end else begin
            st_d    = StMisaligned;
            state_d = SFinish;
          end
        end
      end
      SSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_last) begin
          state_d = SRootLoad;
        end
      end
      SRootLoad: begin
        cmd_o.w_from_root = 1'b1;
        state_d           = STry;
      end
      STry: begin
        cmd_o.mod_start = 1'b1;
        cmd_o.mod_sel_w = 1'b1;
        state_d         = SModW;
      end
      SModW: begin
        cmd_o.mod_sel_w = 1'b1;
        if (sts_i.mod_done) begin
          if (sts_i.rem_zero) begin
            st_d    = StOk;
            state_d = SFinish;
          end else begin
            cmd_o.w_dec = 1'b1;
            state_d     = STry;
          end
        end
      end
      SFinish: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          m_tvalid_d     = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      st_q       <= StOk;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      st_q       <= st_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

endmodule

FILE: rtl/dma_width_divider_finder_top.sv
// ----------------------------------------------------------------------------
// dma_width_divider_finder_top
// Finds the largest divisor of a DMA length not above its integer root.
// ----------------------------------------------------------------------------
// Sequence: a zero length is flagged; else the bit-serial remainder unit
//   checks the length against the unit size and flags a misalignment; else
//   the integer root is taken and divisors are tried downward on that unit.
// Throughput: one transaction at a time; the next is taken once the result
//   is in the output register. Reset clears all control state at once.
module dma_width_divider_finder_top #(
  parameter int unsigned LENGTH_BITS = dwdf_pkg::LengthBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // length[31:0], unit_size[63:32]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // divider[15:0], status[17:16], zero
);
  import dwdf_pkg::*;

  localparam int unsigned LenW = (LENGTH_BITS > FieldW) ? FieldW : LENGTH_BITS;

  cmd_t                cmd;
  sts_t                sts;
  logic [DividerW-1:0] divider;
  logic [StatusW-1:0]  status;

  dwdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dwdf_dp #(
    .LEN_W(LenW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .length_i    (s_axis_tdata_i[31:0]),
    .unit_size_i (s_axis_tdata_i[63:32]),
    .sts_o       (sts),
    .divider_o   (divider),
    .status_o    (status)
  );

  assign m_axis_tdata_o = {6'b0, status, divider};

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dma_width_divider_finder_top. A queue of length /
// transfer size pairs is driven into the input stream with random gaps; each
// accepted transaction is predicted (status, then integer root and downward
// divisor search) and compared field by field with the output stream, which
// is stalled at random and once held off long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;
  import dwdf_pkg::*;

  localparam int unsigned NumRandom = 80;
  localparam int unsigned MaxTrials = 300;
  localparam int unsigned HoldAt    = 30;
  localparam int unsigned HoldLen   = 400;
  localparam int unsigned DrainWait = 200;

  typedef struct {
    logic [31:0] length;
    logic [31:0] size;
    int unsigned gap;
  } xfer_t;

  typedef struct packed {
    logic [DividerW-1:0] divider;
    status_e             status;
  } width_res_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [63:0] s_data = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;

  xfer_t       pending_q[$];
  width_res_t  width_q[$];
  int unsigned n_total;
  int unsigned n_sent = 0;
  int unsigned n_recv = 0;
  int unsigned n_ok = 0;
  int unsigned n_zero = 0;
  int unsigned n_misaligned = 0;
  int unsigned n_errors = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        hold_on = 1'b0;
  logic        hold_used = 1'b0;
  width_res_t  acc_res;
  int unsigned acc_trials;
  width_res_t  exp_res;

  dma_width_divider_finder_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // trials = number of candidate widths tried in the downward search
  function automatic void find_width(input logic [31:0] len, input logic [31:0] size,
                                     output width_res_t res, output int unsigned trials);
    logic [31:0] unit;
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] probe;
    logic [31:0] trial;
    logic [31:0] w;
    res.divider = '0;
    res.status  = StOk;
    trials      = 0;
    if (len == 0) begin
      res.status = StZero;
    end else begin
      unit = (size == 0) ? DefaultUnit : size;
      if (len % unit != 0) begin
        res.status = StMisaligned;
      end else begin
        rem   = len;
        root  = '0;
        probe = 32'h4000_0000;
        while (probe > rem) probe = probe >> 2;
        while (probe != 0) begin
          trial = root + probe;
          if (rem >= trial) begin
            rem  = rem - trial;
            root = (root >> 1) + probe;
          end else begin
            root = root >> 1;
          end
          probe = probe >> 2;
        end
        w = root;
        while (w > 0) begin
          trials++;
          if (len % w == 0) break;
          w--;
        end
        res.divider = w[DividerW-1:0];
      end
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid  <= 1'b0;
      s_data   <= '0;
      gap_left <= 0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        find_width(s_data[31:0], s_data[63:32], acc_res, acc_trials);
        width_q.push_back(acc_res);
        n_sent <= n_sent + 1;
        case (acc_res.status)
          StOk:    n_ok <= n_ok + 1;
          StZero:  n_zero <= n_zero + 1;
          default: n_misaligned <= n_misaligned + 1;
        endcase
      end
      if (!s_valid || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_valid  <= 1'b0;
        end else if (pending_q.size() > 0) begin
          s_data   <= {pending_q[0].size, pending_q[0].length};
          gap_left <= pending_q[0].gap;
          s_valid  <= 1'b1;
          void'(pending_q.pop_front());
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off so the block backs up its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_on   <= 1'b0;
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && n_sent == HoldAt) begin
      hold_on   <= 1'b1;
      hold_left <= HoldLen;
      hold_used <= 1'b1;
    end else if (hold_on) begin
      if (hold_left == 1) hold_on <= 1'b0;
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready    <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        n_recv <= n_recv + 1;
        if (width_q.size() == 0) begin
          $error("unexpected transaction: divider %0d status %0d",
                 m_axis_tdata_o[15:0], m_axis_tdata_o[17:16]);
          n_errors++;
        end else begin
          exp_res = width_q.pop_front();
          if (m_axis_tdata_o[15:0] !== exp_res.divider) begin
            $error("divider: expected %0d, got %0d", exp_res.divider, m_axis_tdata_o[15:0]);
            n_errors++;
          end
          if (m_axis_tdata_o[17:16] !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, m_axis_tdata_o[17:16]);
            n_errors++;
          end
          if (m_axis_tdata_o[23:18] !== 6'd0) begin
            $error("padding: expected 0, got %0d", m_axis_tdata_o[23:18]);
            n_errors++;
          end
        end
        if (n_recv >= 20 && n_recv < 45) begin
          stall_left <= 0;
          m_ready    <= !hold_on;
        end else begin
          stall_left <= $urandom_range(0, 4);
          m_ready    <= 1'b0;
        end
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_ready    <= 1'b0;
      end else begin
        m_ready <= !hold_on;
      end
    end
  end

  initial begin
    xfer_t       x;
    width_res_t  res;
    int unsigned trials;
    int unsigned n_rand;
    int unsigned pick;
    logic [31:0] unit;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] a_max;
    logic [31:0] k_hi;
    logic [63:0] prod;

    // directed: zero length, default unit, extremes, primes, perfect squares
    x.gap = 0;
    x.length = 32'd0;          x.size = 32'd0;          pending_q.push_back(x);
    x.length = 32'd0;          x.size = 32'hFFFF_FFFF;  pending_q.push_back(x);
    x.length = 32'hFFFF_FFFF;  x.size = 32'd1;          pending_q.push_back(x);
    x.length = 32'hFFFF_FFFF;  x.size = 32'd0;          pending_q.push_back(x);
    x.length = 32'hFFFF_FFFF;  x.size = 32'hFFFF_FFFF;  pending_q.push_back(x);
    x.length = 32'd16;         x.size = 32'd0;          pending_q.push_back(x);
    x.length = 32'd32;         x.size = 32'd0;          pending_q.push_back(x);
    x.length = 32'd48;         x.size = 32'd0;          pending_q.push_back(x);
    x.length = 32'd1;          x.size = 32'd1;          pending_q.push_back(x);
    x.length = 32'd2;          x.size = 32'd1;          pending_q.push_back(x);
    x.length = 32'd3;          x.size = 32'd3;          pending_q.push_back(x);
    x.length = 32'd15;         x.size = 32'd5;          pending_q.push_back(x);
    x.length = 32'd24;         x.size = 32'd8;          pending_q.push_back(x);
    x.length = 32'h4000_0000;  x.size = 32'h4000_0000;  pending_q.push_back(x);
    x.length = 32'h8000_0000;  x.size = 32'hFFFF_FFFF;  pending_q.push_back(x);
    x.length = 32'd17;         x.size = 32'h8000_0000;  pending_q.push_back(x);
    x.length = 32'd65521;      x.size = 32'd1;          pending_q.push_back(x);
    x.length = 32'd4294836225; x.size = 32'd65535;      pending_q.push_back(x);
    x.length = 32'hFFFF_0000;  x.size = 32'h0001_0000;  pending_q.push_back(x);
    x.length = 32'd4294967291; x.size = 32'd0;          pending_q.push_back(x);
    x.length = 32'd4294967291; x.size = 32'd2;          pending_q.push_back(x);
    x.length = 32'd17;         x.size = 32'd0;          pending_q.push_back(x);

    n_rand = 0;
    while (n_rand < NumRandom) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        case ($urandom_range(0, 3))
          0:       x.size = 32'd0;
          1:       x.size = $urandom_range(1, 64);
          2:       x.size = 32'd1 << $urandom_range(0, 12);
          default: x.size = $urandom_range(1, 4096);
        endcase
        unit  = (x.size == 0) ? DefaultUnit : x.size;
        a_max = 32'd1 << $urandom_range(4, 16);
        k_hi  = (a_max / unit > 0) ? a_max / unit : 32'd1;
        a     = unit * $urandom_range(1, k_hi);
        b     = a + $urandom_range(0, 100);
        prod  = 64'(a) * 64'(b);
        if (prod[63:32] != 0) continue;
        x.length = prod[31:0];
      end else if (pick < 7) begin
        x.length = 32'd0;
        x.size   = $urandom;
      end else begin
        x.length = $urandom;
        case ($urandom_range(0, 3))
          0:       x.size = $urandom;
          1:       x.size = $urandom_range(0, 32);
          2:       x.size = x.length;
          default: begin
            x.size   = $urandom_range(2, 4096);
            x.length = x.size * $urandom_range(1, 1000) + $urandom_range(1, x.size - 1);
          end
        endcase
      end
      find_width(x.length, x.size, res, trials);
      if (trials > MaxTrials) continue;
      x.gap = (n_rand >= 50 && n_rand < 70) ? 0 : $urandom_range(0, 4);
      pending_q.push_back(x);
      n_rand++;
    end
    n_total = pending_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_sent < n_total || width_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Ran %0d transactions (%0d ok, %0d zero length, %0d misaligned), %0d results.",
             n_sent, n_ok, n_zero, n_misaligned, n_recv);
    $display("Included random gaps and stalls and one %0d-cycle output hold-off.", HoldLen);
    if (n_errors == 0 && width_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dwdf_pkg.sv
rtl/dwdf_mod.sv
rtl/dwdf_dp.sv
rtl/dwdf_ctrl.sv
rtl/dma_width_divider_finder_top.sv
verif/testbench.sv
